>>> src/dnd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnd_pkg
// Shared types and constants of the netboot DHCP discover filter.
// ----------------------------------------------------------------------------
package dnd_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 2048;
  localparam int unsigned MAX_UUID_BYTES  = 32;
  localparam int unsigned POS_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned UAW    = $clog2(MAX_UUID_BYTES);
  localparam int unsigned UCNT_W = $clog2(MAX_UUID_BYTES + 1);

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_SHORT       = 4'd1;
  localparam logic [3:0] ST_IPLEN       = 4'd2;
  localparam logic [3:0] ST_BAD_HDR     = 4'd3;
  localparam logic [3:0] ST_IP_CSUM     = 4'd4;
  localparam logic [3:0] ST_UDP_CSUM    = 4'd5;
  localparam logic [3:0] ST_PORTS       = 4'd6;
  localparam logic [3:0] ST_MAGIC       = 4'd7;
  localparam logic [3:0] ST_NOT_REQUEST = 4'd8;
  localparam logic [3:0] ST_NOT_DISC    = 4'd9;
  localparam logic [3:0] ST_MISSING     = 4'd10;
  localparam logic [3:0] ST_UUID_LONG   = 4'd11;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  status;
    logic [47:0] src_mac;
    logic [5:0]  uuid_count;
    logic [4:0]  uuid_index;
    logic [7:0]  uuid_byte;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic [3:0]        status;
    logic [47:0]       src_mac;
    logic [UCNT_W-1:0] count;
    logic              bank;
  } summary_t;

  typedef struct packed {
    logic           we;
    logic [UAW:0]   addr;
    logic [7:0]     data;
  } uuid_wr_t;

endpackage

>>> src/dnd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnd_fifo
// Two-entry queue of frame summaries between parser and emitter.
// ----------------------------------------------------------------------------
module dnd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  dnd_pkg::summary_t wdata,
  input  logic              rd,
  output logic              valid,
  output dnd_pkg::summary_t rdata
);

  dnd_pkg::summary_t mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign valid = (count != 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      count <= count + 2'(wr) - 2'(rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> (count != 2'd2 || rd)) else $error("summary queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> valid) else $error("summary queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("summary queue count out of range");

endmodule

>>> src/dnd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnd_front
// Per-byte header parse, checksums and option walk; classifies each frame.
// ----------------------------------------------------------------------------
module dnd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  dnd_pkg::item_t    item,
  output dnd_pkg::uuid_wr_t uwr,
  output logic              sum_push,
  output dnd_pkg::summary_t sum_data
);

  localparam logic [2:0] W_CODE = 3'd0;
  localparam logic [2:0] W_LEN  = 3'd1;
  localparam logic [2:0] W_DATA = 3'd2;
  localparam logic [2:0] W_STOP = 3'd3;
  localparam logic [2:0] W_NDSC = 3'd4;
  localparam logic [2:0] W_ULNG = 3'd5;

  localparam int HF_VERIHL = 0;
  localparam int HF_PROTO  = 1;
  localparam int HF_SPORT  = 2;
  localparam int HF_DPORT  = 3;
  localparam int HF_COOKIE = 4;
  localparam int HF_OP     = 5;

  localparam int PW = dnd_pkg::POS_W;
  localparam int CW = dnd_pkg::UCNT_W;

  logic [PW-1:0] pos, pos_next;
  logic [15:0]   iptl, iptl_next, udpl, udpl_next;
  logic [19:0]   ipsum, ipsum_next;
  logic [27:0]   udpsum, udpsum_next;
  logic [31:0]   chk, chk_next;
  logic [5:0]    flags, flags_next;
  logic [2:0]    walk, walk_next;
  logic [7:0]    ocode, ocode_next, oleft, oleft_next;
  logic          ofirst, ofirst_next;
  logic [2:0]    marks, marks_next;
  logic [47:0]   mac, mac_next;
  logic [CW-1:0] ulen, ulen_next;
  logic          bank;

  logic          snap_valid;
  logic [PW-1:0] s_len;
  logic [15:0]   s_iptl, s_udpl;
  logic [19:0]   s_ipsum;
  logic [27:0]   s_udpsum;
  logic [31:0]   s_chk;
  logic [5:0]    s_flags;
  logic [2:0]    s_walk, s_marks;
  logic [47:0]   s_mac;
  logic [CW-1:0] s_ulen;
  logic          s_bank;

  logic [7:0]    b;
  logic [15:0]   w;
  logic          active;

  function automatic logic [15:0] fold(input logic [27:0] s);
    logic [16:0] a;
    logic [16:0] c;
    a = 17'(s[27:16]) + 17'(s[15:0]);
    c = a + 17'(a[16]);
    return ~c[15:0];
  endfunction

  assign b      = item.frame_byte;
  assign w      = pos[0] ? {8'd0, b} : {b, 8'd0};
  assign active = take && (pos < PW'(dnd_pkg::MAX_FRAME_BYTES));

  always_comb begin
    pos_next    = pos;
    iptl_next   = iptl;
    udpl_next   = udpl;
    ipsum_next  = ipsum;
    udpsum_next = udpsum;
    chk_next    = chk;
    flags_next  = flags;
    walk_next   = walk;
    ocode_next  = ocode;
    oleft_next  = oleft;
    ofirst_next = ofirst;
    marks_next  = marks;
    mac_next    = mac;
    ulen_next   = ulen;
    uwr         = '0;
    uwr.addr    = {bank, ulen[dnd_pkg::UAW-1:0]};
    uwr.data    = b;
    if (active) begin
      pos_next = pos + PW'(1);
      if (pos >= 6 && pos < 12) mac_next = {mac[39:0], b};
      if (pos >= 14 && pos < 34 && pos != 24 && pos != 25) begin
        ipsum_next = ipsum + 20'(w);
      end
      if (pos >= 18 && (17'(pos) - 17'd14) < 17'(iptl) &&
          (pos == 23 || (pos >= 26 && pos < 40) || pos >= 42)) begin
        udpsum_next = udpsum + 28'(w);
      end
      case (pos)
        14:  flags_next[HF_VERIHL] = (b == 8'h45);
        16:  iptl_next = {b, 8'd0};
        17:  iptl_next = {iptl[15:8], b};
        23:  flags_next[HF_PROTO] = (b == 8'd17);
        24:  chk_next[31:24] = b;
        25:  chk_next[23:16] = b;
        34:  flags_next[HF_SPORT] = (b == 8'd0);
        35:  flags_next[HF_SPORT] = flags[HF_SPORT] && (b == 8'd68);
        36:  flags_next[HF_DPORT] = (b == 8'd0);
        37:  flags_next[HF_DPORT] = flags[HF_DPORT] && (b == 8'd67);
        38:  udpl_next = {b, 8'd0};
        39:  udpl_next = {udpl[15:8], b};
        40:  chk_next[15:8] = b;
        41:  chk_next[7:0] = b;
        42:  flags_next[HF_OP] = (b == 8'd1);
        278: flags_next[HF_COOKIE] = (b == 8'h63);
        279: flags_next[HF_COOKIE] = flags[HF_COOKIE] && (b == 8'h82);
        280: flags_next[HF_COOKIE] = flags[HF_COOKIE] && (b == 8'h53);
        281: flags_next[HF_COOKIE] = flags[HF_COOKIE] && (b == 8'h63);
        default: ;
      endcase
      if (pos >= 282) begin
        case (walk)
          W_CODE: begin
            if (b == 8'h00 || b == 8'hff) begin
              walk_next = W_STOP;
            end else begin
              ocode_next = b;
              walk_next  = W_LEN;
            end
          end
          W_LEN: begin
            oleft_next  = b;
            ofirst_next = 1'b1;
            walk_next   = (b == 8'd0) ? W_CODE : W_DATA;
            if (ocode == 8'h35 && b == 8'd0) begin
              walk_next = W_NDSC;
            end else if (ocode == 8'h61) begin
              if (9'(b) > 9'(dnd_pkg::MAX_UUID_BYTES)) begin
                walk_next = W_ULNG;
              end else begin
                marks_next[2] = 1'b1;
                ulen_next     = '0;
              end
            end
          end
          W_DATA: begin
            oleft_next  = oleft - 8'd1;
            ofirst_next = 1'b0;
            if (oleft == 8'd1) walk_next = W_CODE;
            if (ocode == 8'h35 && ofirst) begin
              if (b != 8'd1) walk_next = W_NDSC;
              else marks_next[0] = 1'b1;
            end else if (ocode == 8'h37 && b == 8'h42) begin
              marks_next[1] = 1'b1;
            end else if (ocode == 8'h61 &&
                         ulen < CW'(dnd_pkg::MAX_UUID_BYTES)) begin
              uwr.we    = 1'b1;
              ulen_next = ulen + CW'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last_byte) begin
      s_len    <= pos_next;
      s_iptl   <= iptl_next;
      s_udpl   <= udpl_next;
      s_ipsum  <= ipsum_next;
      s_udpsum <= udpsum_next;
      s_chk    <= chk_next;
      s_flags  <= flags_next;
      s_walk   <= walk_next;
      s_marks  <= marks_next;
      s_mac    <= mac_next;
      s_ulen   <= ulen_next;
      s_bank   <= bank;
    end
    if (rst || (take && item.last_byte)) begin
      pos    <= '0;
      iptl   <= '0;
      udpl   <= '0;
      ipsum  <= '0;
      udpsum <= '0;
      chk    <= '0;
      flags  <= '0;
      walk   <= W_CODE;
      ocode  <= '0;
      oleft  <= '0;
      ofirst <= 1'b0;
      marks  <= '0;
      mac    <= '0;
      ulen   <= '0;
    end else begin
      pos    <= pos_next;
      iptl   <= iptl_next;
      udpl   <= udpl_next;
      ipsum  <= ipsum_next;
      udpsum <= udpsum_next;
      chk    <= chk_next;
      flags  <= flags_next;
      walk   <= walk_next;
      ocode  <= ocode_next;
      oleft  <= oleft_next;
      ofirst <= ofirst_next;
      marks  <= marks_next;
      mac    <= mac_next;
      ulen   <= ulen_next;
    end
    if (rst) begin
      bank       <= 1'b0;
      snap_valid <= 1'b0;
    end else begin
      snap_valid <= take && item.last_byte;
      if (take && item.last_byte) bank <= ~bank;
    end
  end

  // classify the captured frame
  logic [3:0] st;
  logic [15:0] ipchk, udpchk;

  assign ipchk  = s_chk[31:16];
  assign udpchk = s_chk[15:0];

  always_comb begin
    if (s_len < PW'(42)) begin
      st = dnd_pkg::ST_SHORT;
    end else if (17'(s_iptl) + 17'd14 > 17'(s_len)) begin
      st = dnd_pkg::ST_IPLEN;
    end else if (!s_flags[HF_VERIHL] || !s_flags[HF_PROTO] ||
                 17'(s_iptl) != 17'(s_udpl) + 17'd20) begin
      st = dnd_pkg::ST_BAD_HDR;
    end else if (ipchk != fold(28'(s_ipsum))) begin
      st = dnd_pkg::ST_IP_CSUM;
    end else if (udpchk != 16'd0 && udpchk != fold(s_udpsum + 28'(s_udpl))) begin
      st = dnd_pkg::ST_UDP_CSUM;
    end else if (!s_flags[HF_SPORT] || !s_flags[HF_DPORT]) begin
      st = dnd_pkg::ST_PORTS;
    end else if (s_len < PW'(282) || !s_flags[HF_COOKIE]) begin
      st = dnd_pkg::ST_MAGIC;
    end else if (!s_flags[HF_OP]) begin
      st = dnd_pkg::ST_NOT_REQUEST;
    end else if (s_walk == W_NDSC) begin
      st = dnd_pkg::ST_NOT_DISC;
    end else if (s_walk == W_ULNG) begin
      st = dnd_pkg::ST_UUID_LONG;
    end else if (s_marks != 3'b111) begin
      st = dnd_pkg::ST_MISSING;
    end else begin
      st = dnd_pkg::ST_OK;
    end
  end

  assign sum_push         = snap_valid;
  assign sum_data.status  = st;
  assign sum_data.src_mac = s_mac;
  assign sum_data.count   = (st == dnd_pkg::ST_OK) ? s_ulen : '0;
  assign sum_data.bank    = s_bank;

endmodule

>>> src/dnd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnd_back
// UUID buffer (two banks) and result emitter, one result per cycle while popped.
// ----------------------------------------------------------------------------
module dnd_back (
  input  logic              clk,
  input  logic              rst,
  input  dnd_pkg::uuid_wr_t uwr,
  input  logic              sum_valid,
  input  dnd_pkg::summary_t sum,
  output logic              sum_pop,
  output logic              empty,
  input  logic              pop,
  output dnd_pkg::result_t  result
);

  localparam int AW = dnd_pkg::UAW;
  localparam int CW = dnd_pkg::UCNT_W;

  logic [7:0] mem [2 * dnd_pkg::MAX_UUID_BYTES];
  logic [7:0] rd_data;

  logic [AW-1:0] k;
  logic [CW-1:0] n;
  logic          load, is_last, out_valid;
  logic          r_acc, r_last, r_zero;
  logic [3:0]    r_status;
  logic [47:0]   r_mac;
  logic [5:0]    r_count;
  logic [4:0]    r_index;

  assign n       = (sum.count == '0) ? CW'(1) : sum.count;
  assign is_last = (CW'(k) + CW'(1) == n);
  assign load    = sum_valid && (!out_valid || pop);
  assign sum_pop = load && is_last;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (uwr.we) mem[uwr.addr] <= uwr.data;
    if (load) begin
      rd_data  <= mem[{sum.bank, k}];
      r_acc    <= (sum.status == dnd_pkg::ST_OK);
      r_status <= sum.status;
      r_mac    <= sum.src_mac;
      r_count  <= 6'(sum.count);
      r_zero   <= (sum.count == '0);
      r_index  <= (sum.count == '0) ? 5'd0 : 5'(k);
      r_last   <= is_last;
    end
    if (rst) begin
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        k <= is_last ? '0 : k + AW'(1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.accepted    = r_acc;
  assign result.status      = r_status;
  assign result.src_mac     = r_mac;
  assign result.uuid_count  = r_count;
  assign result.uuid_index  = r_index;
  assign result.uuid_byte   = r_zero ? 8'd0 : rd_data;
  assign result.last_result = r_last;

endmodule

>>> src/dhcp_netboot_discover_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_netboot_discover_filter
// Filters received frames for netboot DHCP DISCOVER requests.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle while not full. Frame summaries are
// registered and queued; results leave one per cycle while popped (1 to 32
// per frame). Two finished frames may wait in the result path; a third
// frame's bytes are held off (full) until the older one has left. Synchronous
// reset clears all control state; the UUID buffer is not cleared.
module dhcp_netboot_discover_filter (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  dnd_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output dnd_pkg::result_t result
);

  dnd_pkg::uuid_wr_t uwr;
  dnd_pkg::summary_t fsum, qsum;
  logic              fpush, qvalid, qpop, take, done;
  logic [1:0]        pending;

  assign take = push && !full;
  assign done = pop && !empty && result.last_result;
  assign full = (pending == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + 2'(take && item.last_byte) - 2'(done);
    end
  end

  dnd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .uwr      (uwr),
    .sum_push (fpush),
    .sum_data (fsum)
  );

  dnd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (fpush),
    .wdata (fsum),
    .rd    (qpop),
    .valid (qvalid),
    .rdata (qsum)
  );

  dnd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .uwr       (uwr),
    .sum_valid (qvalid),
    .sum       (qsum),
    .sum_pop   (qpop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3) else $error("pending frame count out of range");
  a_single_when_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.uuid_count == 6'd0) |-> result.last_result)
    else $error("frame with no UUID must give one result");
  a_accept_ok: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.accepted == (result.status == dnd_pkg::ST_OK)))
    else $error("verdict and status disagree");

endmodule

>>> tb/sv/dhcp_netboot_discover_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_netboot_discover_filter_test
// Streams generated Ethernet/IPv4/UDP/DHCP frames byte by byte into the
// discover filter. Frames are mostly well formed with valid checksums and
// random contents; others carry one targeted defect or variant (length, header,
// checksum, port, cookie, opcode, option errors, truncation, oversize, noise).
// A byte-level predictor computes the verdict and UUID transfers of each frame,
// and every result transfer is checked field by field in order.
// ----------------------------------------------------------------------------
module dhcp_netboot_discover_filter_test;

  localparam logic [7:0] OPT_PAD  = 8'h00;
  localparam logic [7:0] OPT_MSG  = 8'h35;
  localparam logic [7:0] OPT_PRL  = 8'h37;
  localparam logic [7:0] OPT_BOOT = 8'h42;
  localparam logic [7:0] OPT_UUID = 8'h61;
  localparam logic [7:0] OPT_END  = 8'hff;
  localparam logic [7:0] DHCP_DISCOVER = 8'd1;
  localparam logic [7:0] BOOTREQUEST   = 8'd1;

  localparam int B_VER = 0, B_PROTO = 1, B_SPORT = 2, B_DPORT = 3, B_COOKIE = 4, B_OP = 5;
  localparam int HOLD_CYCLES = 1500;

  typedef enum logic [2:0] {W_CODE, W_LEN, W_DATA, W_STOP, W_NOTDISC, W_LONG} walk_e;
  typedef enum int {
    K_GOOD, K_SHORT, K_IPLEN, K_BADHDR, K_IPCSUM, K_UDPCSUM, K_PORTS, K_MAGIC,
    K_OPCODE, K_NOTDISC, K_MISSING, K_UUIDLONG, K_UDPZERO, K_CUT, K_HUGE,
    K_MSGLEN0, K_UUIDTWICE, K_NOCOOKIE, K_NOISE, K_COUNT
  } frame_kind_e;
  typedef enum logic [1:0] {C_BYTE, C_DRAIN, C_HOLD, C_CALM} ctl_e;
  typedef struct {
    dnd_pkg::item_t it;
    ctl_e           ctl;
  } pend_t;

  logic             clk = 0;
  logic             rst = 1;
  logic             push = 0;
  logic             pop = 0;
  dnd_pkg::item_t   item = '0;
  logic             full, empty;
  dnd_pkg::result_t result;

  dhcp_netboot_discover_filter dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  pend_t            pend_q[$];
  dnd_pkg::result_t verdict_q[$];
  int      err_count = 0;
  logic    acc_in = 0;
  logic    drain_wait = 0;
  logic    hold_go = 0;
  logic    calm = 0;
  int      tx_gap = 0;
  int      rx_gap = 0;
  int      hold_cnt = 0;

  // frame parser state
  logic [dnd_pkg::POS_W-1:0] fpos;
  logic [15:0]      iptot_q, udpl_q;
  logic [19:0]      ipsum;
  logic [27:0]      udsum;
  logic [31:0]      cks;
  logic [7:0]       hflags;
  walk_e            wst;
  logic [7:0]       ocode, oleft, oseen;
  logic [2:0]       marks;
  logic [47:0]      mac;
  logic [7:0]       umem[dnd_pkg::MAX_UUID_BYTES];
  logic [7:0]       ulen;

  function automatic logic [15:0] fold16(logic [31:0] s);
    s = (s >> 16) + (s & 32'hffff);
    s = s + (s >> 16);
    return ~s[15:0];
  endfunction

  task automatic clear_frame();
    fpos = '0; iptot_q = '0; udpl_q = '0; ipsum = '0; udsum = '0; cks = '0;
    hflags = '0; wst = W_CODE; ocode = '0; oleft = '0; oseen = '0; marks = '0;
    mac = '0; ulen = '0;
  endtask

  task automatic walk_option(logic [7:0] b);
    logic stop;
    stop = 0;
    case (wst)
      W_CODE: begin
        if (b == OPT_PAD || b == OPT_END) wst = W_STOP;
        else begin
          ocode = b;
          wst = W_LEN;
        end
      end
      W_LEN: begin
        oleft = b;
        oseen = '0;
        if (ocode == OPT_MSG && b == 0) wst = W_NOTDISC;
        else if (ocode == OPT_UUID && b > dnd_pkg::MAX_UUID_BYTES) wst = W_LONG;
        else begin
          if (ocode == OPT_UUID) begin
            marks[2] = 1;
            ulen = '0;
          end
          wst = (b == 0) ? W_CODE : W_DATA;
        end
      end
      W_DATA: begin
        if (ocode == OPT_MSG && oseen == 0) begin
          if (b != DHCP_DISCOVER) begin
            wst = W_NOTDISC;
            stop = 1;
          end else marks[0] = 1;
        end else if (ocode == OPT_PRL && b == OPT_BOOT) marks[1] = 1;
        else if (ocode == OPT_UUID && ulen < dnd_pkg::MAX_UUID_BYTES) begin
          umem[ulen[4:0]] = b;
          ulen = ulen + 8'd1;
        end
        if (!stop) begin
          oseen = oseen + 8'd1;
          oleft = oleft - 8'd1;
          if (oleft == 0) wst = W_CODE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic absorb_byte(int unsigned p, logic [7:0] b);
    logic [15:0] w;
    w = p[0] ? {8'h00, b} : {b, 8'h00};
    if (p >= 6 && p < 12) mac = {mac[39:0], b};
    if (p >= 14 && p < 34 && p != 24 && p != 25) ipsum = ipsum + 20'(w);
    if (p >= 18 && (p - 14) < iptot_q && (p == 23 || (p >= 26 && p < 40) || p >= 42))
      udsum = udsum + 28'(w);
    case (p)
      14:  hflags[B_VER] = (b == 8'h45);
      16:  iptot_q[15:8] = b;
      17:  iptot_q[7:0] = b;
      23:  hflags[B_PROTO] = (b == 8'd17);
      24:  cks[31:24] = b;
      25:  cks[23:16] = b;
      34:  hflags[B_SPORT] = (b == 0);
      35:  hflags[B_SPORT] = hflags[B_SPORT] && b == 8'd68;
      36:  hflags[B_DPORT] = (b == 0);
      37:  hflags[B_DPORT] = hflags[B_DPORT] && b == 8'd67;
      38:  udpl_q[15:8] = b;
      39:  udpl_q[7:0] = b;
      40:  cks[15:8] = b;
      41:  cks[7:0] = b;
      42:  hflags[B_OP] = (b == BOOTREQUEST);
      278: hflags[B_COOKIE] = (b == 8'h63);
      279: hflags[B_COOKIE] = hflags[B_COOKIE] && b == 8'h82;
      280: hflags[B_COOKIE] = hflags[B_COOKIE] && b == 8'h53;
      281: hflags[B_COOKIE] = hflags[B_COOKIE] && b == 8'h63;
      default: ;
    endcase
    if (p >= 282) walk_option(b);
  endtask

  function automatic logic [3:0] frame_verdict();
    int unsigned len;
    len = fpos;
    if (len < 42) return dnd_pkg::ST_SHORT;
    if (iptot_q + 14 > len) return dnd_pkg::ST_IPLEN;
    if (!hflags[B_VER] || !hflags[B_PROTO] || iptot_q != 20 + udpl_q)
      return dnd_pkg::ST_BAD_HDR;
    if (cks[31:16] != fold16(ipsum)) return dnd_pkg::ST_IP_CSUM;
    if (cks[15:0] != 0 && cks[15:0] != fold16(udsum + udpl_q)) return dnd_pkg::ST_UDP_CSUM;
    if (!hflags[B_SPORT] || !hflags[B_DPORT]) return dnd_pkg::ST_PORTS;
    if (len < 282 || !hflags[B_COOKIE]) return dnd_pkg::ST_MAGIC;
    if (!hflags[B_OP]) return dnd_pkg::ST_NOT_REQUEST;
    if (wst == W_NOTDISC) return dnd_pkg::ST_NOT_DISC;
    if (wst == W_LONG) return dnd_pkg::ST_UUID_LONG;
    if (marks != 3'b111) return dnd_pkg::ST_MISSING;
    return dnd_pkg::ST_OK;
  endfunction

  task automatic filter_byte(dnd_pkg::item_t it);
    logic [3:0] st;
    int cnt, n;
    dnd_pkg::result_t r;
    if (fpos < dnd_pkg::MAX_FRAME_BYTES) begin
      absorb_byte(fpos, it.frame_byte);
      fpos = fpos + 1'b1;
    end
    if (it.last_byte) begin
      st = frame_verdict();
      cnt = (st == dnd_pkg::ST_OK) ? int'(ulen) : 0;
      n = (cnt == 0) ? 1 : cnt;
      for (int k = 0; k < n; k++) begin
        r.accepted = (st == dnd_pkg::ST_OK);
        r.status = st;
        r.src_mac = mac;
        r.uuid_count = 6'(cnt);
        r.uuid_index = (cnt == 0) ? 5'd0 : 5'(k);
        r.uuid_byte = (cnt == 0) ? 8'd0 : umem[k];
        r.last_result = (k + 1 == n);
        verdict_q.push_back(r);
      end
      clear_frame();
    end
  endtask

  task automatic add_ctl(ctl_e c);
    pend_t e;
    e.it = '0;
    e.ctl = c;
    pend_q.push_back(e);
  endtask

  task automatic add_frame(frame_kind_e k);
    logic [7:0] f[$];
    logic [7:0] opts[$];
    int miss, rot, n, idx, L, reps, iptot, udpl, cut;
    logic [31:0] si, su;
    logic [15:0] ci, cu;
    pend_t e;
    miss = (k == K_MISSING) ? $urandom_range(0, 2) : 3;
    rot = $urandom_range(0, 2);
    if ($urandom_range(0, 1)) begin
      n = $urandom_range(0, 6);
      opts.push_back($urandom_range(1, 50));
      opts.push_back(n);
      repeat (n) opts.push_back($urandom_range(0, 255));
    end
    for (int j = 0; j < 3; j++) begin
      case ((j + rot) % 3)
        0: if (miss != 0) begin
          opts.push_back(OPT_MSG);
          if (k == K_MSGLEN0) opts.push_back(8'd0);
          else begin
            opts.push_back(8'd1);
            opts.push_back((k == K_NOTDISC) ? $urandom_range(2, 255) : DHCP_DISCOVER);
          end
        end
        1: if (miss != 1) begin
          n = $urandom_range(1, 6);
          idx = $urandom_range(0, n - 1);
          opts.push_back(OPT_PRL);
          opts.push_back(n);
          for (int i = 0; i < n; i++) opts.push_back((i == idx) ? OPT_BOOT : $urandom_range(0, 255));
        end
        default: if (miss != 2) begin
          reps = (k == K_UUIDTWICE) ? 2 : 1;
          repeat (reps) begin
            L = (k == K_UUIDLONG) ? $urandom_range(33, 255) : $urandom_range(0, 32);
            opts.push_back(OPT_UUID);
            opts.push_back(L);
            for (int i = 0; i < L && i < 40; i++) opts.push_back($urandom_range(0, 255));
          end
        end
      endcase
    end
    opts.push_back(OPT_END);
    repeat ($urandom_range(0, 3)) opts.push_back($urandom_range(0, 255));

    iptot = 268 + opts.size();
    udpl = iptot - 20;
    if (k == K_IPLEN) begin
      iptot += $urandom_range(1, 50);
      udpl = iptot - 20;
    end
    for (int i = 0; i < 282; i++) f.push_back($urandom_range(0, 255));
    foreach (opts[i]) f.push_back(opts[i]);
    f[12] = 8'h08; f[13] = 8'h00; f[14] = 8'h45;
    f[16] = iptot[15:8]; f[17] = iptot[7:0]; f[23] = 8'd17;
    f[34] = 0; f[35] = 8'd68; f[36] = 0; f[37] = 8'd67;
    f[38] = udpl[15:8]; f[39] = udpl[7:0]; f[42] = BOOTREQUEST;
    f[278] = 8'h63; f[279] = 8'h82; f[280] = 8'h53; f[281] = 8'h63;
    case (k)
      K_BADHDR: case ($urandom_range(0, 2))
        0: f[14] = 8'h46;
        1: f[23] = 8'd6;
        default: f[39] = f[39] ^ 8'h01;
      endcase
      K_PORTS:  f[$urandom_range(34, 37)] ^= $urandom_range(1, 255);
      K_MAGIC:  f[$urandom_range(278, 281)] ^= $urandom_range(1, 255);
      K_OPCODE: f[42] = $urandom_range(0, 1) ? 8'd0 : $urandom_range(2, 255);
      default: ;
    endcase
    si = 0;
    for (int p = 14; p < 34; p++)
      if (p != 24 && p != 25) si += (p % 2) ? f[p] : {f[p], 8'h00};
    su = udpl;
    for (int p = 18; p < f.size(); p++)
      if (p - 14 < iptot && (p == 23 || (p >= 26 && p < 40) || p >= 42))
        su += (p % 2) ? f[p] : {f[p], 8'h00};
    ci = fold16(si);
    cu = fold16(su);
    if (k == K_UDPZERO) cu = 0;
    if (k == K_IPCSUM) ci ^= 16'h1 << $urandom_range(0, 15);
    if (k == K_UDPCSUM) cu ^= 16'h1 << $urandom_range(0, 15);
    f[24] = ci[15:8]; f[25] = ci[7:0]; f[40] = cu[15:8]; f[41] = cu[7:0];

    case (k)
      K_SHORT:    cut = $urandom_range(1, 41);
      K_CUT:      cut = 282 + $urandom_range(1, opts.size() - 1);
      K_NOCOOKIE: cut = $urandom_range(42, 281);
      default:    cut = f.size();
    endcase
    if (cut < f.size()) f = f[0:cut-1];
    if (k == K_HUGE) begin
      cut = $urandom_range(2049, 2100);
      while (f.size() < cut) f.push_back($urandom_range(0, 255));
    end
    if (k == K_NOISE) begin
      f.delete();
      repeat ($urandom_range(1, 400)) f.push_back($urandom_range(0, 255));
    end
    foreach (f[i]) begin
      e.it.frame_byte = f[i];
      e.it.last_byte = (i == f.size() - 1);
      e.ctl = C_BYTE;
      pend_q.push_back(e);
    end
  endtask

  function automatic frame_kind_e pick_kind();
    int k;
    if ($urandom_range(0, 9) < 6) return K_GOOD;
    k = $urandom_range(1, K_COUNT - 1);
    if (k == K_HUGE) k = K_GOOD;
    return frame_kind_e'(k);
  endfunction

  // sender
  always @(negedge clk) begin : sender
    pend_t e;
    if (rst) push <= 0;
    else if (push && !acc_in) ;
    else if (drain_wait) begin
      push <= 0;
      if (verdict_q.size() == 0) drain_wait <= 0;
    end else if (tx_gap > 0) begin
      push <= 0;
      tx_gap <= tx_gap - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      push <= 0;
      tx_gap <= $urandom_range(0, 10);
    end else if (pend_q.size() > 0) begin
      e = pend_q.pop_front();
      case (e.ctl)
        C_BYTE: begin
          item <= e.it;
          push <= 1;
        end
        C_DRAIN: begin
          push <= 0;
          drain_wait <= 1;
        end
        C_HOLD: begin
          push <= 0;
          hold_go <= 1;
        end
        default: begin
          push <= 0;
          calm <= 1;
        end
      endcase
    end else push <= 0;
  end

  // receiver
  always @(negedge clk) begin
    if (rst) pop <= 0;
    else if (hold_go && hold_cnt < HOLD_CYCLES) begin
      pop <= 0;
      hold_cnt <= hold_cnt + 1;
    end else if (rx_gap > 0) begin
      pop <= 0;
      rx_gap <= rx_gap - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      pop <= 0;
      rx_gap <= $urandom_range(0, 10);
    end else pop <= 1;
  end

  // monitor
  always @(posedge clk) begin : monitor
    dnd_pkg::result_t x;
    if (!rst) begin
      acc_in <= push && !full;
      if (push && !full) filter_byte(item);
      if (pop && !empty) begin
        if (verdict_q.size() == 0) begin
          $error("result transfer with nothing expected: %p", result);
          err_count++;
        end else begin
          x = verdict_q.pop_front();
          if (result.accepted !== x.accepted) begin
            $error("accepted: expected %0d, got %0d", x.accepted, result.accepted);
            err_count++;
          end
          if (result.status !== x.status) begin
            $error("status: expected %0d, got %0d", x.status, result.status);
            err_count++;
          end
          if (result.src_mac !== x.src_mac) begin
            $error("src_mac: expected %h, got %h", x.src_mac, result.src_mac);
            err_count++;
          end
          if (result.uuid_count !== x.uuid_count) begin
            $error("uuid_count: expected %0d, got %0d", x.uuid_count, result.uuid_count);
            err_count++;
          end
          if (result.uuid_index !== x.uuid_index) begin
            $error("uuid_index: expected %0d, got %0d", x.uuid_index, result.uuid_index);
            err_count++;
          end
          if (result.uuid_byte !== x.uuid_byte) begin
            $error("uuid_byte: expected %h, got %h", x.uuid_byte, result.uuid_byte);
            err_count++;
          end
          if (result.last_result !== x.last_result) begin
            $error("last_result: expected %0d, got %0d", x.last_result, result.last_result);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("dhcp_netboot_discover_filter_test: errors");
    $finish;
  end

  initial begin
    clear_frame();
    for (int k = 0; k < K_COUNT; k++) add_frame(frame_kind_e'(k));
    add_ctl(C_DRAIN);
    add_ctl(C_HOLD);
    repeat (40) add_frame(pick_kind());
    add_ctl(C_DRAIN);
    repeat (30) add_frame(pick_kind());
    add_ctl(C_CALM);
    repeat (12) add_frame(pick_kind());
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    do @(posedge clk);
    while (pend_q.size() != 0 || push || drain_wait || verdict_q.size() != 0);
    repeat (50) @(posedge clk);
    if (err_count == 0 && verdict_q.size() == 0)
      $display("dhcp_netboot_discover_filter_test: clean");
    else
      $display("dhcp_netboot_discover_filter_test: errors");
    $finish;
  end

endmodule
